// ===== hw/rtl/xmcr_pkg.sv =====
// Shared constants and types for the XMODEM checksum receiver.
package xmcr_pkg;

    localparam int BLOCK_BYTES       = 128;
    localparam int INDEX_BITS        = $clog2(BLOCK_BYTES);
    localparam int ADDR_BITS_DEFAULT = 24;
    localparam int ADDR_OUT_BITS     = 24;
    localparam int SIZE_BITS         = 25;
    localparam int INTERVAL_BITS     = 24;

    localparam logic [INTERVAL_BITS-1:0] NAK_INTERVAL_RESET = 24'd2000000;

    localparam logic [7:0] CH_SOH = 8'h01;
    localparam logic [7:0] CH_EOT = 8'h04;
    localparam logic [7:0] CH_ACK = 8'h06;
    localparam logic [7:0] CH_NAK = 8'h15;
    localparam logic [7:0] CH_CAN = 8'h18;
    localparam logic [7:0] CH_NONE = 8'h00;

    localparam logic [1:0] ST_OK       = 2'd0;
    localparam logic [1:0] ST_CANCEL   = 2'd1;
    localparam logic [1:0] ST_PROTOCOL = 2'd2;
    localparam logic [1:0] ST_OVERFLOW = 2'd3;

    localparam logic CMD_BYTE = 1'b0;
    localparam logic CMD_TICK = 1'b1;

    typedef struct packed {
        logic                     reply_valid;
        logic [7:0]               reply_byte;
        logic                     write_valid;
        logic [ADDR_OUT_BITS-1:0] write_address;
        logic [7:0]               write_data;
        logic                     finished;
        logic [1:0]               status;
        logic [SIZE_BITS-1:0]     total_bytes;
    } res_t;

endpackage

// ===== hw/rtl/xmodem_checksum_receiver_core.sv =====
// XMODEM checksum receiver: protocol state machine with a two-entry result buffer.
//
// Takes one word per cycle while s_ready is high (a received byte or a timer tick)
// and gives at most one result word for it: a reply byte (ACK/NAK), a data byte to
// store at its address, and/or the end of the transfer with its status and total
// size. Every word is processed by the protocol state machine; results go through
// an output register backed by a skid register, so s_ready stays high as long as
// the skid register is empty. The store holds 2**min(ADDR_BITS, 24) bytes; a block
// that would not fit ends the transfer with overflow status. After the transfer
// ends, words are accepted and dropped until reset. The user must write nak_interval
// on the cfg port only while the block is idle; the block does not enforce this.
module xmodem_checksum_receiver_core #(
    parameter int ADDR_BITS = xmcr_pkg::ADDR_BITS_DEFAULT
) (
    input  logic                                     aclk,
    input  logic                                     aresetn,
    input  logic                                     cfg_valid,
    output logic                                     cfg_ready,
    input  logic [xmcr_pkg::INTERVAL_BITS-1:0]       cfg_wdata,
    input  logic                                     s_valid,
    output logic                                     s_ready,
    input  logic                                     s_cmd,
    input  logic [7:0]                               s_rx_byte,
    output logic                                     m_valid,
    input  logic                                     m_ready,
    output logic                                     m_reply_valid,
    output logic [7:0]                               m_reply_byte,
    output logic                                     m_write_valid,
    output logic [xmcr_pkg::ADDR_OUT_BITS-1:0]       m_write_address,
    output logic [7:0]                               m_write_data,
    output logic                                     m_finished,
    output logic [1:0]                               m_status,
    output logic [xmcr_pkg::SIZE_BITS-1:0]           m_total_bytes
);
    import xmcr_pkg::*;

    localparam int CAP_BITS = (ADDR_BITS > 24) ? 24 : ADDR_BITS;
    localparam logic [SIZE_BITS:0] CAPACITY = (SIZE_BITS+1)'(1) << CAP_BITS;

    localparam logic [2:0] PH_HEADER = 3'd0;
    localparam logic [2:0] PH_NUMBER = 3'd1;
    localparam logic [2:0] PH_COMPL  = 3'd2;
    localparam logic [2:0] PH_DATA   = 3'd3;
    localparam logic [2:0] PH_SUM    = 3'd4;

    logic [INTERVAL_BITS-1:0] nak_interval_reg;
    logic [2:0]               phase_reg, phase_next;
    logic                     started_reg, started_next;
    logic [7:0]               expected_reg, expected_next;
    logic [7:0]               got_block_reg, got_block_next;
    logic [INDEX_BITS-1:0]    index_reg, index_next;
    logic [7:0]               sum_reg, sum_next;
    logic [SIZE_BITS-1:0]     size_reg, size_next;
    logic [INTERVAL_BITS-1:0] tick_reg, tick_next;
    logic                     done_reg, done_next;

    logic                     out_valid_reg, skid_valid_reg;
    res_t                     out_reg, skid_reg;

    logic                     accept;
    logic                     res_valid;
    res_t                     res;
    logic [INTERVAL_BITS-1:0] tick_inc;
    logic [SIZE_BITS:0]       size_after;
    logic                     out_free;

    assign cfg_ready = 1'b1;
    assign s_ready   = !skid_valid_reg;
    assign accept    = s_valid && s_ready;
    assign out_free  = !out_valid_reg || m_ready;

    assign tick_inc   = tick_reg + INTERVAL_BITS'(1);
    assign size_after = {1'b0, size_reg} + (SIZE_BITS+1)'(BLOCK_BYTES);

    always_comb begin
        phase_next    = phase_reg;
        started_next  = started_reg;
        expected_next = expected_reg;
        got_block_next = got_block_reg;
        index_next    = index_reg;
        sum_next      = sum_reg;
        size_next     = size_reg;
        tick_next     = tick_reg;
        done_next     = done_reg;
        res_valid     = 1'b0;
        res           = '0;

        if (accept && !done_reg) begin
            if (s_cmd == CMD_TICK) begin
                if (phase_reg == PH_HEADER && !started_reg) begin
                    if (tick_inc >= nak_interval_reg) begin
                        tick_next       = '0;
                        res_valid       = 1'b1;
                        res.reply_valid = 1'b1;
                        res.reply_byte  = CH_NAK;
                    end else begin
                        tick_next = tick_inc;
                    end
                end
            end else begin
                case (phase_reg)
                    PH_HEADER: begin
                        tick_next = '0;
                        if (s_rx_byte == CH_EOT) begin
                            done_next       = 1'b1;
                            res_valid       = 1'b1;
                            res.reply_valid = 1'b1;
                            res.reply_byte  = CH_ACK;
                            res.finished    = 1'b1;
                            res.status      = ST_OK;
                            res.total_bytes = size_reg;
                        end else if (s_rx_byte == CH_CAN) begin
                            done_next       = 1'b1;
                            res_valid       = 1'b1;
                            res.finished    = 1'b1;
                            res.status      = ST_CANCEL;
                            res.total_bytes = size_reg;
                        end else if (s_rx_byte == CH_SOH) begin
                            started_next = 1'b1;
                            if (size_after > CAPACITY) begin
                                done_next       = 1'b1;
                                res_valid       = 1'b1;
                                res.finished    = 1'b1;
                                res.status      = ST_OVERFLOW;
                                res.total_bytes = size_reg;
                            end else begin
                                phase_next = PH_NUMBER;
                            end
                        end else if (started_reg) begin
                            done_next       = 1'b1;
                            res_valid       = 1'b1;
                            res.finished    = 1'b1;
                            res.status      = ST_PROTOCOL;
                            res.total_bytes = size_reg;
                        end
                    end
                    PH_NUMBER: begin
                        if (s_rx_byte != expected_reg) begin
                            phase_next      = PH_HEADER;
                            res_valid       = 1'b1;
                            res.reply_valid = 1'b1;
                            res.reply_byte  = CH_NAK;
                        end else begin
                            got_block_next = s_rx_byte;
                            phase_next     = PH_COMPL;
                        end
                    end
                    PH_COMPL: begin
                        if ((got_block_reg ^ s_rx_byte) != 8'hff) begin
                            phase_next      = PH_HEADER;
                            res_valid       = 1'b1;
                            res.reply_valid = 1'b1;
                            res.reply_byte  = CH_NAK;
                        end else begin
                            index_next = '0;
                            sum_next   = '0;
                            phase_next = PH_DATA;
                        end
                    end
                    PH_DATA: begin
                        res_valid         = 1'b1;
                        res.write_valid   = 1'b1;
                        res.write_address = size_reg[ADDR_OUT_BITS-1:0]
                                            + ADDR_OUT_BITS'(index_reg);
                        res.write_data    = s_rx_byte;
                        sum_next          = sum_reg + s_rx_byte;
                        index_next        = index_reg + INDEX_BITS'(1);
                        if (index_reg == INDEX_BITS'(BLOCK_BYTES - 1)) begin
                            phase_next = PH_SUM;
                        end
                    end
                    PH_SUM: begin
                        phase_next      = PH_HEADER;
                        res_valid       = 1'b1;
                        res.reply_valid = 1'b1;
                        if (sum_reg != s_rx_byte) begin
                            res.reply_byte = CH_NAK;
                        end else begin
                            res.reply_byte = CH_ACK;
                            expected_next  = expected_reg + 8'd1;
                            size_next      = size_after[SIZE_BITS-1:0];
                        end
                    end
                    default: begin
                        phase_next = PH_HEADER;
                    end
                endcase
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            nak_interval_reg <= NAK_INTERVAL_RESET;
            phase_reg        <= PH_HEADER;
            started_reg      <= 1'b0;
            expected_reg     <= 8'd1;
            got_block_reg    <= '0;
            index_reg        <= '0;
            sum_reg          <= '0;
            size_reg         <= '0;
            tick_reg         <= '0;
            done_reg         <= 1'b0;
        end else begin
            if (cfg_valid && cfg_ready) begin
                nak_interval_reg <= cfg_wdata;
            end
            phase_reg     <= phase_next;
            started_reg   <= started_next;
            expected_reg  <= expected_next;
            got_block_reg <= got_block_next;
            index_reg     <= index_next;
            sum_reg       <= sum_next;
            size_reg      <= size_next;
            tick_reg      <= tick_next;
            done_reg      <= done_next;
        end
    end

    // result buffer: output register, skid register behind it
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            out_valid_reg  <= 1'b0;
            skid_valid_reg <= 1'b0;
        end else if (out_free) begin
            out_valid_reg  <= skid_valid_reg || res_valid;
            skid_valid_reg <= 1'b0;
        end else if (res_valid) begin
            skid_valid_reg <= 1'b1;
        end
    end

    always_ff @(posedge aclk) begin
        if (out_free) begin
            out_reg <= skid_valid_reg ? skid_reg : res;
        end else if (res_valid) begin
            skid_reg <= res;
        end
    end

    assign m_valid         = out_valid_reg;
    assign m_reply_valid   = out_reg.reply_valid;
    assign m_reply_byte    = out_reg.reply_byte;
    assign m_write_valid   = out_reg.write_valid;
    assign m_write_address = out_reg.write_address;
    assign m_write_data    = out_reg.write_data;
    assign m_finished      = out_reg.finished;
    assign m_status        = out_reg.status;
    assign m_total_bytes   = out_reg.total_bytes;

    a_skid_behind_out: assert property (@(posedge aclk) disable iff (!aresetn)
        skid_valid_reg |-> out_valid_reg)
        else $error("skid register holds a word while output register is empty");

    a_done_sticks: assert property (@(posedge aclk) disable iff (!aresetn)
        done_reg |=> done_reg)
        else $error("finished transfer left the done state");

    a_write_not_finish: assert property (@(posedge aclk) disable iff (!aresetn)
        (out_valid_reg && out_reg.write_valid) |-> !out_reg.finished)
        else $error("data write and transfer end in one word");

    a_index_in_data: assert property (@(posedge aclk) disable iff (!aresetn)
        (index_reg != '0) |-> (phase_reg == PH_DATA))
        else $error("data index nonzero outside the data phase");

    a_size_aligned: assert property (@(posedge aclk) disable iff (!aresetn)
        size_reg[INDEX_BITS-1:0] == '0)
        else $error("size count not a multiple of the block size");

endmodule
